// ===== rtl/rc4_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rc4_pkg;

   localparam int KEY_BYTES_DEF = 16;
   localparam int KEY_BYTES_MAX = 16;
   localparam int TABLE_DEPTH   = 256;

   // Sequencer steps (program addresses)
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILL,
      ST_KS_RD,
      ST_KS_ACC,
      ST_KS_SWAPA,
      ST_KS_SWAPB,
      ST_KS_DONE,
      ST_GEN_I,
      ST_GEN_J,
      ST_GEN_SWAPA,
      ST_GEN_SWAPB,
      ST_GEN_RD,
      ST_GEN_OUT
   } step_type;

   typedef enum logic [1:0] {
      RD_CNT,
      RD_J_NEXT,
      RD_I_NEXT,
      RD_SUM
   } rd_sel_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_FILL,
      WR_CNT_RDATA,
      WR_J_A,
      WR_I_RDATA
   } wr_sel_type;

   typedef enum logic [1:0] {
      J_HOLD,
      J_CLEAR,
      J_KEY,
      J_ADD
   } j_op_type;

   typedef enum logic [1:0] {
      I_HOLD,
      I_CLEAR,
      I_INC
   } i_op_type;

   typedef enum logic [1:0] {
      SEQ_NEXT,
      SEQ_LOOP,
      SEQ_DISPATCH,
      SEQ_EMIT
   } seq_type;

   typedef struct packed {
      rd_sel_type rd_sel;
      wr_sel_type wr_sel;
      j_op_type   j_op;
      i_op_type   i_op;
      logic       a_ld;
      logic       b_ld;
      logic       cnt_inc;
      logic       kidx_clr;
      logic       kidx_inc;
      logic       set_keyed;
      seq_type    seq;
      step_type   target;
   } ucode_type;

   function automatic ucode_type ucode(input step_type s);
      ucode_type w;
      w = '{rd_sel: RD_CNT, wr_sel: WR_NONE, j_op: J_HOLD, i_op: I_HOLD,
            a_ld: 1'b0, b_ld: 1'b0, cnt_inc: 1'b0, kidx_clr: 1'b0,
            kidx_inc: 1'b0, set_keyed: 1'b0, seq: SEQ_NEXT, target: ST_IDLE};
      case (s)
         ST_IDLE: begin
            w.seq = SEQ_DISPATCH;
         end
         ST_FILL: begin
            w.wr_sel   = WR_FILL;
            w.j_op     = J_CLEAR;
            w.cnt_inc  = 1'b1;
            w.kidx_clr = 1'b1;
            w.seq      = SEQ_LOOP;
            w.target   = ST_FILL;
         end
         ST_KS_RD: begin
            w.rd_sel = RD_CNT;
         end
         ST_KS_ACC: begin
            w.a_ld   = 1'b1;
            w.j_op   = J_KEY;
            w.rd_sel = RD_J_NEXT;
         end
         ST_KS_SWAPA: begin
            w.wr_sel = WR_CNT_RDATA;
         end
         ST_KS_SWAPB: begin
            w.wr_sel   = WR_J_A;
            w.cnt_inc  = 1'b1;
            w.kidx_inc = 1'b1;
            w.seq      = SEQ_LOOP;
            w.target   = ST_KS_RD;
         end
         ST_KS_DONE: begin
            w.i_op      = I_CLEAR;
            w.j_op      = J_CLEAR;
            w.set_keyed = 1'b1;
         end
         ST_GEN_I: begin
            w.i_op   = I_INC;
            w.rd_sel = RD_I_NEXT;
         end
         ST_GEN_J: begin
            w.a_ld   = 1'b1;
            w.j_op   = J_ADD;
            w.rd_sel = RD_J_NEXT;
         end
         ST_GEN_SWAPA: begin
            w.b_ld   = 1'b1;
            w.wr_sel = WR_I_RDATA;
         end
         ST_GEN_SWAPB: begin
            w.wr_sel = WR_J_A;
         end
         ST_GEN_RD: begin
            w.rd_sel = RD_SUM;
         end
         ST_GEN_OUT: begin
            w.rd_sel = RD_SUM;
            w.seq    = SEQ_EMIT;
            w.target = ST_IDLE;
         end
         default: begin
            w.seq = SEQ_DISPATCH;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/rc4_stream_cipher.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                        Direction  Contents
// req       req_tvalid/tready/tdata/tlast  in       tdata[7:0] data_in, tlast last_of_message
// rsp       rsp_tvalid/tready/tdata/tlast  out      tdata[7:0] data_out, tlast end_of_message
// csr       csr_psel/penable/pwrite/...    in/out   key_low @0x0, key_high @0x8 (64-bit)
//
// The first byte of a message first waits for keying (loading the identity table, a
// read, an accumulate and two swap writes per key schedule position, then clearing the
// indices); every byte then takes six sequencer steps (two reads, two swap writes, the
// keystream read and the output step) before a new transfer is taken.
// Reset clears the sequencer, indices and keyed flag; the table is rebuilt before use.
// req_tready is high only in the idle step; the output step holds while rsp is full.

module rc4_stream_cipher
   import rc4_pkg::*;
#(
   parameter int KEY_BYTES = KEY_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] data_in
   input  wire logic        req_tlast,    // last_of_message

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,    // [7:0] data_out
   output logic             rsp_tlast,    // end_of_message

   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output logic [63:0]      csr_prdata,
   output logic             csr_pready
);

   // key length clamped to 1..16
   localparam int KEY_LEN = (KEY_BYTES < 1) ? 1 :
                            (KEY_BYTES > KEY_BYTES_MAX) ? KEY_BYTES_MAX : KEY_BYTES;
   localparam logic [3:0] KIDX_LAST = 4'(KEY_LEN - 1);

   // ---------------- config registers ----------------
   logic [63:0] key_low_ff, key_high_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = csr_paddr[3] ? key_high_ff : key_low_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
      end else if (csr_wr) begin
         if (csr_paddr[3]) begin
            key_high_ff <= csr_pwdata;
         end else begin
            key_low_ff <= csr_pwdata;
         end
      end
   end

   // ---------------- sequencer ----------------
   step_type  pc_ff, pc_in;
   ucode_type uw;

   logic [7:0] cnt_ff, cnt_in;       // fill / schedule position
   logic [3:0] kidx_ff, kidx_in;     // key byte position
   logic [7:0] i_ff, i_in;
   logic [7:0] j_ff, j_in;
   logic [7:0] a_ff, a_in;
   logic [7:0] b_ff, b_in;
   logic       keyed_ff, keyed_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic       rsp_last_ff, rsp_last_in;

   logic       req_xfer;
   logic       out_free;
   logic       emit;

   // state table: one write and one registered read per cycle
   logic [7:0] perm_mem [TABLE_DEPTH];
   logic [7:0] rdata_ff;
   logic [7:0] raddr;
   logic       we;
   logic [7:0] waddr, wdata;

   logic [127:0] key_vec;
   logic [7:0]   key_byte;

   assign key_vec  = {key_high_ff, key_low_ff};
   assign key_byte = key_vec[{kidx_ff, 3'b000} +: 8];

   assign uw         = ucode(pc_ff);
   assign req_tready = (pc_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign emit       = (uw.seq == SEQ_EMIT) && out_free;

   // next step
   always_comb begin
      pc_in = pc_ff;
      case (uw.seq)
         SEQ_NEXT: begin
            pc_in = step_type'(pc_ff + 4'd1);
         end
         SEQ_LOOP: begin
            pc_in = (cnt_ff != 8'hFF) ? uw.target : step_type'(pc_ff + 4'd1);
         end
         SEQ_DISPATCH: begin
            if (req_xfer) begin
               pc_in = keyed_ff ? ST_GEN_I : ST_FILL;
            end
         end
         SEQ_EMIT: begin
            if (out_free) begin
               pc_in = uw.target;
            end
         end
         default: begin
            pc_in = ST_IDLE;
         end
      endcase
   end

   // datapath
   always_comb begin
      cnt_in   = uw.cnt_inc ? cnt_ff + 8'd1 : cnt_ff;
      kidx_in  = kidx_ff;
      if (uw.kidx_clr) begin
         kidx_in = '0;
      end else if (uw.kidx_inc) begin
         kidx_in = (kidx_ff == KIDX_LAST) ? 4'd0 : kidx_ff + 4'd1;
      end

      case (uw.i_op)
         I_CLEAR: i_in = '0;
         I_INC:   i_in = i_ff + 8'd1;
         default: i_in = i_ff;
      endcase

      case (uw.j_op)
         J_CLEAR: j_in = '0;
         J_KEY:   j_in = j_ff + rdata_ff + key_byte;
         J_ADD:   j_in = j_ff + rdata_ff;
         default: j_in = j_ff;
      endcase

      a_in = uw.a_ld ? rdata_ff : a_ff;
      b_in = uw.b_ld ? rdata_ff : b_ff;

      case (uw.rd_sel)
         RD_CNT:    raddr = cnt_ff;
         RD_J_NEXT: raddr = j_in;
         RD_I_NEXT: raddr = i_in;
         RD_SUM:    raddr = a_ff + b_ff;
         default:   raddr = cnt_ff;
      endcase

      we    = 1'b1;
      waddr = cnt_ff;
      wdata = cnt_ff;
      case (uw.wr_sel)
         WR_FILL: begin
            waddr = cnt_ff;
            wdata = cnt_ff;
         end
         WR_CNT_RDATA: begin
            waddr = cnt_ff;
            wdata = rdata_ff;
         end
         WR_J_A: begin
            waddr = j_ff;
            wdata = a_ff;
         end
         WR_I_RDATA: begin
            waddr = i_ff;
            wdata = rdata_ff;
         end
         default: begin
            we = 1'b0;
         end
      endcase

      data_in = req_xfer ? req_tdata : data_ff;
      last_in = req_xfer ? req_tlast : last_ff;

      keyed_in = keyed_ff;
      if (uw.set_keyed) begin
         keyed_in = 1'b1;
      end else if (emit && last_ff) begin
         keyed_in = 1'b0;   // next message re-keys with the current key
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = data_ff ^ rdata_ff;
         rsp_last_in  = last_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= ST_IDLE;
         cnt_ff       <= '0;
         kidx_ff      <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         keyed_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         cnt_ff       <= cnt_in;
         kidx_ff      <= kidx_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         keyed_ff     <= keyed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      data_ff     <= data_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         perm_mem[waddr] <= wdata;
      end
      rdata_ff <= perm_mem[raddr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire
